[hw/rtl/bqe_pkg.sv]
// shared types, constants and window classification for the bit-quad euler core
package bqe_pkg;

  // field and port widths fixed by the interface
  localparam int CELL_W     = 2;
  localparam int SIZE_W     = 6;
  localparam int EULER_W    = 12;
  localparam int CNT_W      = 10;
  localparam int ADDR_W     = 3;
  localparam int APB_DATA_W = 32;
  localparam int S_TDATA_W  = 8;
  localparam int M_TDATA_W  = 24;

  // board size after reset
  localparam logic [SIZE_W-1:0] SIZE_RESET = 6'd19;

  // register word index of the board size register
  localparam logic REG_BOARD_SIZE = 1'b0;

  // cell codes
  localparam logic [CELL_W-1:0] CELL_EMPTY = 2'd0;
  localparam logic [CELL_W-1:0] CELL_BLACK = 2'd1;
  localparam logic [CELL_W-1:0] CELL_WHITE = 2'd2;

  // window kind hits for one colour
  typedef struct packed {
    logic single;
    logic triple;
    logic diag;
  } quad_hit_t;

  // control flags carried with a cell into the classify stage
  typedef struct packed {
    logic win_en;
    logic row_ge1;
    logic last_col;
    logic last_board;
  } cell_flags_t;

  // classify a 2x2 window (upper-left, upper, left, current) for one colour
  function automatic quad_hit_t classify(input logic [CELL_W-1:0] ul,
                                         input logic [CELL_W-1:0] up,
                                         input logic [CELL_W-1:0] lf,
                                         input logic [CELL_W-1:0] cur,
                                         input logic [CELL_W-1:0] col);
    logic [3:0] mine;
    logic [3:0] empty;
    quad_hit_t  hit;
    mine  = {cur == col, lf == col, up == col, ul == col};
    empty = {cur == CELL_EMPTY, lf == CELL_EMPTY, up == CELL_EMPTY, ul == CELL_EMPTY};
    hit   = '0;
    // any other stone or an unused code spoils the window
    if ((mine | empty) == 4'hF) begin
      case (mine)
        4'h1, 4'h2, 4'h4, 4'h8: hit.single = 1'b1;
        4'h7, 4'hB, 4'hD, 4'hE: hit.triple = 1'b1;
        4'h6, 4'h9:             hit.diag   = 1'b1;
        default:                hit        = '0;
      endcase
    end
    return hit;
  endfunction

endpackage

[hw/rtl/bit_quad_euler_number_core.sv]
// top level: streamed bit-quad euler number of a go board, per colour
//
// Cells enter in row-major order, one per transaction, and the core takes one cell every
// clock cycle unless input is stalled as below. Each cell reads and rewrites its column of
// a one-row line buffer in the accepting cycle; the registered read feeds a classify stage
// that updates six window counters, and on the last cell of the board the black and white
// Euler numbers (times four, 12-bit two's complement) land in an output register as that
// cell leaves the classify stage. The counters then clear for the next board. The output
// register lets the next board stream in while a result waits; only the last cell of a
// further board stalls input until that result is taken. board_size (APB offset 0) is
// clamped to 2..MAX_SIZE; the user writes it only between cells, not enforced by the core.
module bit_quad_euler_number_core #(
  parameter int MAX_SIZE = 32
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // input stream
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [bqe_pkg::S_TDATA_W-1:0]      s_axis_tdata,   // [1:0] cell_req
  // result stream
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [bqe_pkg::M_TDATA_W-1:0]      m_axis_tdata,   // [11:0] euler_black_x4,
                                                             // [23:12] euler_white_x4
  // register port
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [bqe_pkg::ADDR_W-1:0]         paddr,
  input  logic [bqe_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [bqe_pkg::APB_DATA_W-1:0]     prdata,
  output logic                               pready
);
  import bqe_pkg::*;

  localparam int POS_W = (MAX_SIZE > 2) ? $clog2(MAX_SIZE) : 1;
  localparam int EXT_W = (CNT_W + 2 > EULER_W) ? CNT_W + 2 : EULER_W;
  localparam logic [SIZE_W:0] MAX_EXT = (SIZE_W + 1)'(MAX_SIZE);

  // configuration
  logic [SIZE_W-1:0] size_q;
  logic              cfg_wr;
  logic [SIZE_W:0]   size_ext;
  logic [SIZE_W:0]   last_ext;
  logic [POS_W-1:0]  last_idx;

  // raster position
  logic [POS_W-1:0]  col_q, row_q;
  logic              in_acc;
  logic              last_col, last_row;
  logic [CELL_W-1:0] cell_in;

  // line buffer
  logic [CELL_W-1:0] line_mem [MAX_SIZE];
  logic [CELL_W-1:0] upper_q;

  // classify stage
  logic              s1_v_q;
  logic [CELL_W-1:0] cur_q;
  cell_flags_t       s1_q;
  cell_flags_t       flags_d;
  logic              s1_adv;
  logic [CELL_W-1:0] upper_eff;
  logic [CELL_W-1:0] left_q, ul_q;
  quad_hit_t         hit_b, hit_w;

  // counters
  logic [CNT_W-1:0]  bs_q, bt_q, bd_q, ws_q, wt_q, wd_q;
  logic [CNT_W-1:0]  bs_d, bt_d, bd_d, ws_d, wt_d, wd_d;
  logic [EXT_W-1:0]  eul_b, eul_w;

  // output register
  logic               out_v_q;
  logic [EULER_W-1:0] out_b_q, out_w_q;

  // register port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_BOARD_SIZE);
  assign prdata = (paddr[2] == REG_BOARD_SIZE) ? APB_DATA_W'(size_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= SIZE_RESET;
    end else if (cfg_wr) begin
      size_q <= pwdata[SIZE_W-1:0];
    end
  end

  // last index of the clamped board size
  always_comb begin
    size_ext = {1'b0, size_q};
    if (size_ext < (SIZE_W + 1)'(2)) begin
      last_ext = (SIZE_W + 1)'(1);
    end else if (size_ext > MAX_EXT) begin
      last_ext = MAX_EXT - (SIZE_W + 1)'(1);
    end else begin
      last_ext = size_ext - (SIZE_W + 1)'(1);
    end
    last_idx = last_ext[POS_W-1:0];
  end

  // input handshake and position
  assign s1_adv        = s1_v_q && (!s1_q.last_board || !out_v_q || m_axis_tready);
  assign s_axis_tready = !s1_v_q || s1_adv;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign cell_in       = s_axis_tdata[CELL_W-1:0];
  assign last_col      = col_q >= last_idx;
  assign last_row      = row_q >= last_idx;

  always_comb begin
    flags_d.win_en     = (row_q != '0) && (col_q != '0);
    flags_d.row_ge1    = row_q != '0;
    flags_d.last_col   = last_col;
    flags_d.last_board = last_col && last_row;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (in_acc) begin
      if (last_col) begin
        col_q <= '0;
        row_q <= last_row ? '0 : row_q + POS_W'(1);
      end else begin
        col_q <= col_q + POS_W'(1);
      end
    end
  end

  // line buffer, old entry read out as the new cell goes in
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      upper_q        <= line_mem[col_q];
      line_mem[col_q] <= cell_in;
    end
  end

  // classify stage registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s1_q   <= '0;
    end else if (s_axis_tready) begin
      s1_v_q <= in_acc;
      s1_q   <= flags_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      cur_q <= cell_in;
    end
  end

  // window classification
  assign upper_eff = s1_q.row_ge1 ? upper_q : CELL_EMPTY;
  assign hit_b     = classify(ul_q, upper_eff, left_q, cur_q, CELL_BLACK);
  assign hit_w     = classify(ul_q, upper_eff, left_q, cur_q, CELL_WHITE);

  // window registers, cleared at each row end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q <= CELL_EMPTY;
      ul_q   <= CELL_EMPTY;
    end else if (s1_adv) begin
      left_q <= s1_q.last_col ? CELL_EMPTY : cur_q;
      ul_q   <= s1_q.last_col ? CELL_EMPTY : upper_eff;
    end
  end

  // counter increments for this window
  always_comb begin
    bs_d = bs_q + CNT_W'(s1_q.win_en && hit_b.single);
    bt_d = bt_q + CNT_W'(s1_q.win_en && hit_b.triple);
    bd_d = bd_q + CNT_W'(s1_q.win_en && hit_b.diag);
    ws_d = ws_q + CNT_W'(s1_q.win_en && hit_w.single);
    wt_d = wt_q + CNT_W'(s1_q.win_en && hit_w.triple);
    wd_d = wd_q + CNT_W'(s1_q.win_en && hit_w.diag);
  end

  // euler number times four: single - triple + 2 * diagonal
  assign eul_b = EXT_W'(bs_d) - EXT_W'(bt_d) + (EXT_W'(bd_d) << 1);
  assign eul_w = EXT_W'(ws_d) - EXT_W'(wt_d) + (EXT_W'(wd_d) << 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bs_q <= '0;
      bt_q <= '0;
      bd_q <= '0;
      ws_q <= '0;
      wt_q <= '0;
      wd_q <= '0;
    end else if (s1_adv) begin
      if (s1_q.last_board) begin
        bs_q <= '0;
        bt_q <= '0;
        bd_q <= '0;
        ws_q <= '0;
        wt_q <= '0;
        wd_q <= '0;
      end else begin
        bs_q <= bs_d;
        bt_q <= bt_d;
        bd_q <= bd_d;
        ws_q <= ws_d;
        wt_q <= wt_d;
        wd_q <= wd_d;
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (s1_adv && s1_q.last_board) begin
      out_v_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_q.last_board) begin
      out_b_q <= eul_b[EULER_W-1:0];
      out_w_q <= eul_w[EULER_W-1:0];
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {out_w_q, out_b_q};

endmodule

[hw/rtl/bqe_checker.sv]
// port-level checker for the bit-quad euler core, bound to the top level
module bqe_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tvalid,
  input logic                           s_axis_tready,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [bqe_pkg::M_TDATA_W-1:0]  m_axis_tdata,
  input logic                           psel,
  input logic                           penable,
  input logic                           pwrite,
  input logic [bqe_pkg::ADDR_W-1:0]     paddr,
  input logic [bqe_pkg::APB_DATA_W-1:0] pwdata,
  input logic [bqe_pkg::APB_DATA_W-1:0] prdata
);
  import bqe_pkg::*;

  // a stalled result holds its value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // with the output register empty the core never holds off input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output register");

  // a fresh result is preceded by an accepted cell transaction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
    else $error("result without a preceding cell transaction");

  // board size read-back reflects the last write
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel && penable && pwrite && (paddr[2] == REG_BOARD_SIZE)
    |=> (paddr[2] != REG_BOARD_SIZE)
        || (prdata == APB_DATA_W'($past(pwdata[SIZE_W-1:0]))))
    else $error("board size read-back mismatch");

endmodule

bind bit_quad_euler_number_core bqe_checker u_bqe_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .psel          (psel),
  .penable       (penable),
  .pwrite        (pwrite),
  .paddr         (paddr),
  .pwdata        (pwdata),
  .prdata        (prdata)
);
